>>> src/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types, constants and the tempering function of the MT19937 word
// generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int WORD_W       = 32;
    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word SEED_MULT    = 32'd69069;
    localparam t_word DEFAULT_SEED = 32'd4357;
    localparam t_word TWIST_MATRIX = 32'h9908_b0df;
    localparam t_word TEMPER_B     = 32'h9d2c_5680;
    localparam t_word TEMPER_C     = 32'hefc6_0000;

    // Command handed from the front to the back.
    typedef struct packed {
        logic  is_seed;
        t_word seed;
    } t_cmd;

    function automatic t_word temper(input t_word w);
        t_word y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> src/mtg_front.sv
// ----------------------------------------------------------------------------
// mtg_front
// Accepts input transfers, classifies each as seed or draw and queues the
// resulting commands for the back end.
// ----------------------------------------------------------------------------
module mtg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // [31:0] seed_value
    input  logic                 s_axis_tuser,  // [0] mode
    output logic                 o_cmd_valid,
    output mtg_pkg::t_cmd        o_cmd,
    input  logic                 i_cmd_pop
);

    mtg_pkg::t_cmd                     r_q [mtg_pkg::QUEUE_DEPTH];
    logic [mtg_pkg::QPTR_W-1:0]        r_wr_ptr, r_rd_ptr;
    logic [mtg_pkg::QCNT_W-1:0]        r_count;
    logic                              push, pop;
    mtg_pkg::t_cmd                     in_cmd;

    localparam logic [mtg_pkg::QPTR_W-1:0] PTR_LAST =
        mtg_pkg::QPTR_W'(mtg_pkg::QUEUE_DEPTH - 1);
    localparam logic [mtg_pkg::QCNT_W-1:0] CNT_FULL =
        mtg_pkg::QCNT_W'(mtg_pkg::QUEUE_DEPTH);

    assign s_axis_tready = (r_count != CNT_FULL);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_count != '0);
    assign pop           = i_cmd_pop && o_cmd_valid;
    assign o_cmd         = r_q[r_rd_ptr];

    always_comb begin
        in_cmd.is_seed = s_axis_tuser;
        in_cmd.seed    = s_axis_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/mtg_back.sv
// ----------------------------------------------------------------------------
// mtg_back
// Executes queued commands against the state store: seed fill, full twist
// and tempered draw, with a registered output stage.
// ----------------------------------------------------------------------------
module mtg_back #(
    parameter int STATE_WORDS  = mtg_pkg::STATE_WORDS,
    parameter int TWIST_OFFSET = mtg_pkg::TWIST_OFFSET
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  mtg_pkg::t_cmd        i_cmd,
    output logic                 o_cmd_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata   // [31:0] random_word
);

    localparam int AW = $clog2(STATE_WORDS);
    localparam int IW = $clog2(STATE_WORDS + 2);

    localparam logic [AW-1:0] ADDR_LAST = AW'(STATE_WORDS - 1);
    localparam logic [AW-1:0] FAR_FWD   = AW'(TWIST_OFFSET);
    localparam logic [AW-1:0] FAR_BACK  = AW'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [IW-1:0] IDX_FULL  = IW'(STATE_WORDS);
    localparam logic [IW-1:0] IDX_NONE  = IW'(STATE_WORDS + 1);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b000_0001,
        ST_FILL     = 7'b000_0010,
        ST_TW_PRIME = 7'b000_0100,
        ST_TW_RD    = 7'b000_1000,
        ST_TW_WR    = 7'b001_0000,
        ST_DRD      = 7'b010_0000,
        ST_DOUT     = 7'b100_0000
    } t_state;

    mtg_pkg::t_word    mem [STATE_WORDS];
    mtg_pkg::t_word    rd_a, rd_b;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_k, n_k;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_draw, n_draw;
    mtg_pkg::t_word    r_fill, n_fill;
    mtg_pkg::t_word    r_cur, n_cur;
    mtg_pkg::t_word    r_out, n_out;
    logic              r_out_vld, n_out_vld;

    logic              we;
    logic [AW-1:0]     wa, ra_a, ra_b;
    mtg_pkg::t_word    wd;
    logic [AW-1:0]     k_nxt, k_far;
    mtg_pkg::t_word    y, v;
    logic              out_load;

    // Store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_a <= mem[ra_a];
        rd_b <= mem[ra_b];
    end

    assign k_nxt = (r_k == ADDR_LAST) ? '0 : r_k + 1'b1;
    assign k_far = (r_k < FAR_BACK) ? r_k + FAR_FWD : r_k - FAR_BACK;

    assign y = {r_cur[31], rd_a[30:0]};
    assign v = rd_b ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MATRIX : '0);

    assign o_cmd_pop     = (r_state == ST_IDLE) && i_cmd_valid;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_idx    = r_idx;
        n_draw   = r_draw;
        n_fill   = r_fill;
        n_cur    = r_cur;
        n_out    = r_out;
        we       = 1'b0;
        wa       = r_k;
        wd       = r_fill;
        ra_a     = r_idx[AW-1:0];
        ra_b     = k_far;
        out_load = 1'b0;

        case (r_state)
            ST_IDLE: begin
                n_k = '0;
                if (i_cmd_valid) begin
                    if (i_cmd.is_seed) begin
                        n_fill  = i_cmd.seed;
                        n_draw  = 1'b0;
                        n_state = ST_FILL;
                    end else if (r_idx == IDX_NONE) begin
                        // draw before any seed: fill with the default seed first
                        n_fill  = mtg_pkg::DEFAULT_SEED;
                        n_draw  = 1'b1;
                        n_state = ST_FILL;
                    end else if (r_idx == IDX_FULL) begin
                        n_state = ST_TW_PRIME;
                    end else begin
                        n_state = ST_DRD;
                    end
                end
            end
            ST_FILL: begin
                we     = 1'b1;
                n_fill = mtg_pkg::t_word'(r_fill * mtg_pkg::SEED_MULT);
                if (r_k == ADDR_LAST) begin
                    n_k     = '0;
                    n_idx   = IDX_FULL;
                    n_state = r_draw ? ST_TW_PRIME : ST_IDLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_TW_PRIME: begin
                ra_a    = '0;
                n_k     = '0;
                n_state = ST_TW_RD;
            end
            ST_TW_RD: begin
                ra_a = k_nxt;
                ra_b = k_far;
                if (r_k == '0) begin
                    n_cur = rd_a;
                end
                n_state = ST_TW_WR;
            end
            ST_TW_WR: begin
                we    = 1'b1;
                wd    = v;
                n_cur = rd_a;
                if (r_k == ADDR_LAST) begin
                    n_k     = '0;
                    n_idx   = '0;
                    n_state = ST_DRD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_TW_RD;
                end
            end
            ST_DRD: begin
                n_state = ST_DOUT;
            end
            ST_DOUT: begin
                // hold the read address so the word stays put while the output stalls
                if (!r_out_vld || m_axis_tready) begin
                    out_load = 1'b1;
                    n_out    = mtg_pkg::temper(rd_a);
                    n_idx    = r_idx + 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_fill <= n_fill;
        r_cur  <= n_cur;
        r_out  <= n_out;
        r_draw <= n_draw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= IDX_NONE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

>>> src/mersenne_twister_generator_core.sv
// A draw with no twist due passes the front queue, then ST_IDLE, ST_DRD and ST_DOUT.
// The single back-end sequencer takes no new command until the last one is done.
// A twist runs ST_TW_PRIME, then ST_TW_RD and ST_TW_WR in turn for each store word.
// A seed, or the first draw after reset, fills every store word in ST_FILL.
// Reset is synchronous, active low; it empties the queue and marks the store unseeded.
// ----------------------------------------------------------------------------
// mersenne_twister_generator_core
// MT19937 word generator: front queue of seed/draw commands, back end that
// fills, twists and tempers the 624-word store.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_core #(
    parameter int STATE_WORDS  = mtg_pkg::STATE_WORDS,
    parameter int TWIST_OFFSET = mtg_pkg::TWIST_OFFSET
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] random_word
);

    logic          cmd_valid;
    logic          cmd_pop;
    mtg_pkg::t_cmd cmd;

    mtg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    mtg_back #(
        .STATE_WORDS  (STATE_WORDS),
        .TWIST_OFFSET (TWIST_OFFSET)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MT19937 word generator. Seed and draw commands
// are streamed in under random sender and receiver gaps, and every returned
// word is compared against an in-bench model of the fill, twist and temper.
// ----------------------------------------------------------------------------
module tb;

    localparam int   CYCLE_LIMIT  = 3_000_000;
    localparam int   HOLD_CYCLES  = 400;
    localparam int   DRAIN_CYCLES = 2000;
    localparam int   REPORT_MAX   = 10;
    localparam logic MODE_DRAW    = 1'b0;
    localparam logic MODE_SEED    = 1'b1;

    localparam int          N_WORDS     = mtg_pkg::STATE_WORDS;
    localparam int          FAR_OFFSET  = mtg_pkg::TWIST_OFFSET;
    localparam mtg_pkg::t_word HIGH_BIT = 32'h8000_0000;
    localparam mtg_pkg::t_word LOW_BITS = 32'h7fff_ffff;

    // Mirrors the generator store and holds the tempered words still owed.
    class mt_word_scoreboard;
        mtg_pkg::t_word store_words[N_WORDS];
        int unsigned    draw_index;
        mtg_pkg::t_word owed_words[$];
        int             mismatch_count;

        function new();
            draw_index     = N_WORDS + 1;
            mismatch_count = 0;
        endfunction

        function void fill_words(input mtg_pkg::t_word seed);
            store_words[0] = seed;
            for (int i = 1; i < N_WORDS; i++) begin
                store_words[i] = store_words[i-1] * mtg_pkg::SEED_MULT;
            end
            draw_index = N_WORDS;
        endfunction

        function void twist_words();
            mtg_pkg::t_word mixed;
            mtg_pkg::t_word twisted;
            for (int k = 0; k < N_WORDS; k++) begin
                mixed   = (store_words[k] & HIGH_BIT)
                        | (store_words[(k + 1) % N_WORDS] & LOW_BITS);
                twisted = store_words[(k + FAR_OFFSET) % N_WORDS] ^ (mixed >> 1);
                if (mixed[0]) begin
                    twisted = twisted ^ mtg_pkg::TWIST_MATRIX;
                end
                store_words[k] = twisted;
            end
            draw_index = 0;
        endfunction

        function mtg_pkg::t_word temper_word(input mtg_pkg::t_word raw);
            mtg_pkg::t_word t;
            t = raw;
            t = t ^ (t >> 11);
            t = t ^ ((t << 7) & mtg_pkg::TEMPER_B);
            t = t ^ ((t << 15) & mtg_pkg::TEMPER_C);
            t = t ^ (t >> 18);
            return t;
        endfunction

        function void note_command(input logic mode, input mtg_pkg::t_word seed);
            if (mode == MODE_SEED) begin
                fill_words(seed);
                return;
            end
            // Twist when the store is used up; an unseeded store takes the default seed.
            if (draw_index >= N_WORDS) begin
                if (draw_index != N_WORDS) begin
                    fill_words(mtg_pkg::DEFAULT_SEED);
                end
                twist_words();
            end
            owed_words.push_back(temper_word(store_words[draw_index]));
            draw_index++;
        endfunction

        function void flag_error(input string what, input mtg_pkg::t_word want,
                                 input mtg_pkg::t_word got);
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
                $display("ERROR: %s: random_word expected %h, got %h", what, want, got);
            end
        endfunction

        function void check_word(input mtg_pkg::t_word got);
            mtg_pkg::t_word want;
            if (owed_words.size() == 0) begin
                flag_error("unexpected transfer", '0, got);
                return;
            end
            want = owed_words.pop_front();
            if (want !== got) begin
                flag_error("wrong word", want, got);
            end
        endfunction

        function bit is_clean();
            return (mismatch_count == 0) && (owed_words.size() == 0);
        endfunction
    endclass

    logic           i_clk         = 1'b0;
    logic           i_rst_n       = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [31:0]    s_axis_tdata  = '0;    // [31:0] seed_value
    logic           s_axis_tuser  = 1'b0;  // [0] mode
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [31:0]    m_axis_tdata;          // [31:0] random_word

    mt_word_scoreboard word_sb;
    int             tx_idle_pct = 34;
    int             rx_idle_pct = 88;
    int             hold_left   = 0;
    int             cycle_count = 0;

    mersenne_twister_generator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random back-pressure, or a long hold when one is requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Both handshake signals are stable at the falling edge, so a transfer seen
    // here completes at the next rising edge.
    initial begin
        forever begin
            @(negedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                word_sb.check_word(m_axis_tdata);
            end
        end
    end

    task automatic offer_command(input logic mode, input mtg_pkg::t_word seed);
        bit taken;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= seed;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        word_sb.note_command(mode, seed);
    endtask

    // seed_one_in of zero means draws only.
    task automatic run_random(input int count, input int seed_one_in);
        logic mode;
        for (int i = 0; i < count; i++) begin
            if (seed_one_in > 0 && $urandom_range(seed_one_in - 1) == 0) begin
                mode = MODE_SEED;
            end else begin
                mode = MODE_DRAW;
            end
            offer_command(mode, $urandom());
        end
    endtask

    initial begin
        word_sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Draws before any seed fall back to the default seed.
        offer_command(MODE_DRAW, 32'hffff_ffff);
        offer_command(MODE_DRAW, 32'h0000_0000);
        offer_command(MODE_DRAW, 32'h1234_5678);
        offer_command(MODE_SEED, 32'h0000_0000);
        offer_command(MODE_DRAW, 32'hffff_ffff);
        offer_command(MODE_DRAW, 32'h0000_0000);
        offer_command(MODE_SEED, 32'hffff_ffff);
        offer_command(MODE_DRAW, 32'h0000_0000);
        // Back-to-back seeds: only the last one counts.
        offer_command(MODE_SEED, 32'h0000_0001);
        offer_command(MODE_SEED, 32'h8000_0000);
        offer_command(MODE_DRAW, 32'h8000_0000);
        offer_command(MODE_DRAW, 32'h7fff_ffff);
        offer_command(MODE_SEED, mtg_pkg::DEFAULT_SEED);
        offer_command(MODE_DRAW, 32'h0000_0001);
        offer_command(MODE_SEED, 32'ha5a5_a5a5);
        offer_command(MODE_DRAW, 32'h5a5a_5a5a);
        offer_command(MODE_DRAW, 32'ha5a5_a5a5);

        run_random(40, 6);

        // Reseed, then draw from the freshly twisted store with the sender mostly idle.
        offer_command(MODE_SEED, $urandom());
        tx_idle_pct = 88;
        rx_idle_pct = 34;
        run_random(150, 0);

        // Full rate; hold the output long enough to back up the input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left   = HOLD_CYCLES;
        run_random(480, 0);
        s_axis_tvalid <= 1'b0;

        while (word_sb.owed_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (word_sb.owed_words.size() != 0) begin
            $display("ERROR: %0d words never arrived", word_sb.owed_words.size());
        end
        if (word_sb.is_clean()) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> mersenne_twister_generator_core.f
src/mtg_pkg.sv
src/mtg_front.sv
src/mtg_back.sv
src/mersenne_twister_generator_core.sv
tb/tb.sv
